// ===== rtl/deqc_pkg.sv =====
`timescale 1ns / 1ps

package deqc_pkg;

  // Field widths of the stream payloads
  localparam int unsigned REQ_W      = 3;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CNT_OUT_W  = 7;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_USER_W = 2;
  localparam int unsigned OUT_DATA_W = 48;

  // Request codes carried on in_tuser
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_COUNT      = 3'd4
  } req_kind_t;

  // Result status carried on out_tuser
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

endpackage

// ===== rtl/double_ended_queue_with_count_core.sv =====
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values held in a ring buffer.
// Input channel: in_tuser carries the request code (push front, push back,
// pop front, pop back, count matches), in_tdata the value. Result channel:
// out_tuser carries the status, out_tdata the popped value, the match count
// and the occupancy after the request. Exactly one result per request.
// Pushes, failed pops, empty counts and unused codes load the result
// register directly; a successful pop first waits in ST_POP for its
// registered RAM read; a count over N stored entries stays in ST_COUNT
// while the single comparator walks the ring buffer one RAM read per cycle.
// One push is taken per cycle while the output register is free or being
// drained; in_tready is low while a pop or count is in progress.
// Reset empties the queue (front index and entry count cleared); the RAM
// contents are not cleared, since only pushed entries are ever read.
// A result waits in the output register while out_tready is low; a new
// request is taken only when that register is free or being drained.
module double_ended_queue_with_count_core
  import deqc_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tuser: req_type[2:0]
  input  logic [REQ_W-1:0]      in_tuser,
  // in_tdata: value[31:0]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // out_tuser: status[1:0]
  output logic [OUT_USER_W-1:0] out_tuser,
  // out_tdata: popped_value[31:0], match_count[38:32], occupancy[45:39], zeros[47:46]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_COUNT
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         front_r, front_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         walk_r, walk_nxt;
  logic [CW-1:0]         left_r, left_nxt;
  logic [CW-1:0]         match_r, match_nxt;
  logic [VALUE_W-1:0]    key_r, key_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]    out_pop_r, out_pop_nxt;
  logic [CW-1:0]         out_match_r, out_match_nxt;
  logic [CW-1:0]         out_occ_r, out_occ_nxt;

  logic                  in_fire;
  req_kind_t             req_kind;
  logic [VALUE_W-1:0]    req_value;
  logic                  is_full;
  logic                  is_empty;
  logic [AW-1:0]         front_inc;
  logic [AW-1:0]         front_dec;
  logic [AW-1:0]         back_slot;
  logic [AW-1:0]         last_slot;
  logic                  hit;
  logic [CW-1:0]         match_sum;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic [VALUE_W-1:0]    rd_data;

  // Step a ring index forward with wrap
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
    wrap_inc = (ptr == LAST_A) ? '0 : AW'(ptr + 1'b1);
  endfunction

  // Front plus an offset below DEPTH, wrapped by one compare and subtract
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    wrap_add = sum[AW-1:0];
  endfunction

  assign in_fire   = in_tvalid & in_tready;
  assign req_kind  = req_kind_t'(in_tuser);
  assign req_value = in_tdata[VALUE_W-1:0];
  assign is_full   = (count_r == DEPTH_C);
  assign is_empty  = (count_r == '0);

  // Ring addresses around the current front
  assign front_inc = wrap_inc(front_r);
  assign front_dec = (front_r == '0) ? LAST_A : AW'(front_r - 1'b1);
  assign back_slot = wrap_add(front_r, AW'(count_r));
  assign last_slot = wrap_add(front_r, AW'(count_r - 1'b1));

  // Shared comparator for the count walk
  assign hit       = (rd_data == key_r);
  assign match_sum = match_r + CW'(hit);

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);

  deqc_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer: take a request, run its RAM accesses, load the result
  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    walk_nxt       = walk_r;
    left_nxt       = left_r;
    match_nxt      = match_r;
    key_nxt        = key_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_pop_nxt    = out_pop_r;
    out_match_nxt  = out_match_r;
    out_occ_nxt    = out_occ_r;
    wr_en          = 1'b0;
    wr_addr        = back_slot;
    rd_addr        = front_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          // Default result: ok, nothing popped, no matches, occupancy held
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_pop_nxt    = '0;
          out_match_nxt  = '0;
          out_occ_nxt    = count_r;
          case (req_kind)
            REQ_PUSH_FRONT: begin
              if (is_full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                wr_en       = 1'b1;
                wr_addr     = front_dec;
                front_nxt   = front_dec;
                count_nxt   = count_r + 1'b1;
                out_occ_nxt = count_r + 1'b1;
              end
            end
            REQ_PUSH_BACK: begin
              if (is_full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                wr_en       = 1'b1;
                wr_addr     = back_slot;
                count_nxt   = count_r + 1'b1;
                out_occ_nxt = count_r + 1'b1;
              end
            end
            REQ_POP_FRONT: begin
              if (is_empty) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                rd_addr       = front_r;
                front_nxt     = front_inc;
                count_nxt     = count_r - 1'b1;
                state_nxt     = ST_POP;
              end
            end
            REQ_POP_BACK: begin
              if (is_empty) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                rd_addr       = last_slot;
                count_nxt     = count_r - 1'b1;
                state_nxt     = ST_POP;
              end
            end
            REQ_COUNT: begin
              if (!is_empty) begin
                out_valid_nxt = 1'b0;
                rd_addr       = front_r;
                walk_nxt      = front_inc;
                left_nxt      = count_r;
                match_nxt     = '0;
                key_nxt       = req_value;
                state_nxt     = ST_COUNT;
              end
            end
            default: begin
              // Unused codes: ok result, queue untouched
            end
          endcase
        end
      end

      ST_POP: begin
        // Read data is back: hand the popped value out
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_OK;
        out_pop_nxt    = rd_data;
        out_match_nxt  = '0;
        out_occ_nxt    = count_r;
        state_nxt      = ST_IDLE;
      end

      ST_COUNT: begin
        // Compare one entry per cycle and advance the walk
        rd_addr  = walk_r;
        walk_nxt = wrap_inc(walk_r);
        left_nxt = left_r - 1'b1;
        if (left_r == CW'(1)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_pop_nxt    = '0;
          out_match_nxt  = match_sum;
          out_occ_nxt    = count_r;
          state_nxt      = ST_IDLE;
        end else begin
          match_nxt = match_sum;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state, queue pointers and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    walk_r       <= walk_nxt;
    left_r       <= left_nxt;
    match_r      <= match_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_pop_r    <= out_pop_nxt;
    out_match_r  <= out_match_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, CNT_OUT_W'(out_occ_r), CNT_OUT_W'(out_match_r), out_pop_r};

  // Entry count never passes the ring size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above depth");

  // A pending pop or count never finds the output register occupied
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP || state_r == ST_COUNT) |-> !out_valid_r)
    else $error("output register busy during multi-cycle request");

  // A successful push grows the queue by one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !is_full &&
     (req_kind == REQ_PUSH_FRONT || req_kind == REQ_PUSH_BACK))
    |=> count_r == $past(count_r) + 1'b1)
    else $error("push did not grow the queue");

  // Matches found so far never exceed the entries held, and the walk always has entries left
  a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COUNT) |-> (match_r <= count_r && left_r != '0))
    else $error("count walk out of range");

endmodule

// ===== rtl/deqc_ram.sv =====
`timescale 1ns / 1ps

module deqc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb
  import deqc_pkg::*;
();

  localparam int QDEPTH      = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = QDEPTH + 8;

  // Request codes outside the defined set; the block must answer them with an ok result and leave the queue untouched
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   popped;
    logic [CNT_OUT_W-1:0] match_cnt;
    logic [CNT_OUT_W-1:0] occupancy;
  } deque_result_t;

  logic                  clk;
  logic                  rst_n;
  logic [REQ_W-1:0]      in_tuser;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_USER_W-1:0] out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;

  // Shadow copy of the queue contents
  logic [VALUE_W-1:0] shadow_mem [QDEPTH];
  int                 shadow_front;
  int                 shadow_count;

  deque_result_t expected_results [$];
  int            fail_count;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            hold_req;
  int            stall_cycles;

  // Values that repeat often, so count requests find matches
  logic [VALUE_W-1:0] value_pool [6] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                         32'h8000_0000, 32'h7FFF_FFFF, 32'h5A5A_A5A5};

  double_ended_queue_with_count_core #(.DEPTH(QDEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Apply one request to the shadow queue and return the result it should give
  function automatic deque_result_t deque_predict(logic [REQ_W-1:0] kind,
                                                  logic [VALUE_W-1:0] val);
    deque_result_t r;
    int            i;
    r.status    = STAT_OK;
    r.popped    = '0;
    r.match_cnt = '0;
    case (kind)
      REQ_PUSH_FRONT: begin
        if (shadow_count >= QDEPTH) begin
          r.status = STAT_FULL;
        end else begin
          shadow_front = (shadow_front + QDEPTH - 1) % QDEPTH;
          shadow_mem[shadow_front] = val;
          shadow_count++;
        end
      end
      REQ_PUSH_BACK: begin
        if (shadow_count >= QDEPTH) begin
          r.status = STAT_FULL;
        end else begin
          shadow_mem[(shadow_front + shadow_count) % QDEPTH] = val;
          shadow_count++;
        end
      end
      REQ_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.popped = shadow_mem[shadow_front];
          shadow_front = (shadow_front + 1) % QDEPTH;
          shadow_count--;
        end
      end
      REQ_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.popped = shadow_mem[(shadow_front + shadow_count - 1) % QDEPTH];
          shadow_count--;
        end
      end
      REQ_COUNT: begin
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_mem[(shadow_front + i) % QDEPTH] == val) r.match_cnt++;
        end
      end
      default: begin
      end
    endcase
    r.occupancy = shadow_count[CNT_OUT_W-1:0];
    return r;
  endfunction

  // Offer one request after a random gap, predict it once the transfer happens
  task automatic send_req(logic [REQ_W-1:0] kind, logic [VALUE_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tuser  <= kind;
    in_tdata  <= val;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(deque_predict(kind, val));
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(1) == 0) return value_pool[$urandom_range(5)];
    return $urandom();
  endfunction

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    deque_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d, data %h", out_tuser, out_tdata);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_tuser !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, out_tuser);
          fail_count++;
        end
        if (out_tdata[31:0] !== exp_r.popped) begin
          $error("popped_value: expected %0d, actual %0d",
                 $signed(exp_r.popped), $signed(out_tdata[31:0]));
          fail_count++;
        end
        if (out_tdata[38:32] !== exp_r.match_cnt) begin
          $error("match_count: expected %0d, actual %0d", exp_r.match_cnt,
                 out_tdata[38:32]);
          fail_count++;
        end
        if (out_tdata[45:39] !== exp_r.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", exp_r.occupancy, out_tdata[45:39]);
          fail_count++;
        end
      end
    end
  end

  // Drive the result ready; hold it low for a long stretch on request
  initial begin
    int hold_done;
    hold_done = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done++;
      end else if (rst_n) begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Edges of the value range, empty pops, unused codes and small counts
  task automatic test_directed();
    send_req(REQ_POP_FRONT, 32'h0);
    send_req(REQ_POP_BACK, 32'h0);
    send_req(REQ_COUNT, 32'h0);
    send_req(REQ_PUSH_BACK, 32'h7FFF_FFFF);
    send_req(REQ_PUSH_FRONT, 32'h8000_0000);
    send_req(REQ_PUSH_BACK, 32'hFFFF_FFFF);
    send_req(REQ_PUSH_FRONT, 32'h0000_0000);
    send_req(REQ_COUNT, 32'hFFFF_FFFF);
    send_req(REQ_COUNT, 32'h8000_0000);
    send_req(REQ_COUNT, 32'h1234_5678);
    send_req(REQ_POP_FRONT, 32'hFFFF_FFFF);
    send_req(REQ_POP_BACK, 32'h0);
    send_req(REQ_POP_FRONT, 32'h0);
    send_req(REQ_POP_BACK, 32'h0);
    send_req(REQ_POP_BACK, 32'h0);
    send_req(REQ_UNUSED_LO, 32'hFFFF_FFFF);
    send_req(REQ_UNUSED_LO + 3'd1, 32'h0000_0001);
    send_req(REQ_UNUSED_HI, 32'h8000_0000);
    send_req(REQ_PUSH_FRONT, 32'h0000_0001);
    send_req(REQ_PUSH_FRONT, 32'h0000_0001);
    send_req(REQ_COUNT, 32'h0000_0001);
    send_req(REQ_POP_BACK, 32'h0);
    send_req(REQ_POP_FRONT, 32'h0);
  endtask

  // Fill to capacity from both ends, push into a full queue, count it, then drain past empty
  task automatic test_fill_and_drain();
    int i;
    for (i = 0; i < QDEPTH; i++) begin
      send_req(($urandom_range(1) != 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_value());
    end
    send_req(REQ_PUSH_BACK, $urandom());
    send_req(REQ_PUSH_FRONT, $urandom());
    send_req(REQ_COUNT, value_pool[$urandom_range(5)]);
    for (i = 0; i <= QDEPTH; i++) begin
      send_req(($urandom_range(1) != 0) ? REQ_POP_FRONT : REQ_POP_BACK, $urandom());
    end
  endtask

  // Hold the result side off while pushes and then pops are offered
  task automatic test_output_backpressure();
    int i;
    send_idle_pct = 0;
    hold_req++;
    for (i = 0; i < 40; i++) send_req(REQ_PUSH_BACK, pick_value());
    for (i = 0; i < 40; i++) send_req(REQ_POP_FRONT, $urandom());
  endtask

  // Random mix that swings the occupancy between empty and full
  task automatic test_random(int n, int send_pct, int recv_pct);
    int               i;
    int               pick;
    bit               filling;
    logic [REQ_W-1:0] kind;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    filling = 1'b1;
    for (i = 0; i < n; i++) begin
      if (shadow_count == QDEPTH) filling = 1'b0;
      if (shadow_count == 0) filling = 1'b1;
      if ($urandom_range(99) == 0) filling = !filling;
      pick = $urandom_range(99);
      if (pick < 2) begin
        kind = REQ_W'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
      end else if (pick < 12) begin
        kind = REQ_COUNT;
      end else if (pick < (filling ? 72 : 40)) begin
        kind = ($urandom_range(1) != 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
      end else begin
        kind = ($urandom_range(1) != 0) ? REQ_POP_FRONT : REQ_POP_BACK;
      end
      send_req(kind, pick_value());
    end
  endtask

  initial begin
    fail_count    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 0;
    stall_cycles  = 0;
    shadow_front  = 0;
    shadow_count  = 0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tuser      = '0;
    in_tdata      = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 21;
    recv_idle_pct = 50;
    test_directed();
    test_fill_and_drain();
    test_output_backpressure();
    test_random(450, 21, 50);
    test_random(450, 50, 21);
    test_random(450, 0, 0);
    in_tvalid <= 1'b0;

    // Let every outstanding result arrive, then allow for a full count walk
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
